@@ rtl/core/mandel_pkg.sv @@
// shared types, constants and helper functions for the mandelbrot escape-time pixel
package mandel_pkg;

	localparam int LIMIT_W           = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd72;
	localparam int ITER_CEILING_DEF  = 288;
	localparam int FRACTION_BITS_DEF = 60;

	localparam int FX_W    = 64;
	localparam int PROD_W  = 2 * FX_W;
	localparam int HALF_W  = FX_W / 2;
	localparam int DIV_N_W = 20;
	localparam int DIV_D_W = 9;
	localparam int CHAN_W  = 8;
	localparam int T_W     = 11;

	localparam int HUE_SPAN   = 1536;
	localparam int SHADE_SPAN = 159;
	localparam int SHADE_BASE = 96;
	localparam int CHAN_MAX   = 255;

	localparam logic [FX_W-1:0] INT64_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam logic [FX_W-1:0] INT64_MIN = {1'b1, {(FX_W-1){1'b0}}};

	typedef struct packed {
		logic signed [FX_W-1:0] point_real;
		logic signed [FX_W-1:0] point_imag;
	} point_t;

	typedef struct packed {
		logic [23:0]        pixel_rgb;
		logic [LIMIT_W-1:0] iterations_done;
		logic               in_set;
	} result_t;

	typedef struct packed {
		logic            start;
		logic [FX_W-1:0] a;
		logic [FX_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

	// two's complement magnitude, most negative value maps to 2^63
	function automatic logic [FX_W-1:0] mag64(input logic [FX_W-1:0] v);
		return v[FX_W-1] ? (~v + FX_W'(1)) : v;
	endfunction

	// clamp a 66-bit exact sum into the signed 64-bit range
	function automatic logic [FX_W-1:0] sat66(input logic [FX_W+1:0] s);
		logic [FX_W-1:0] r;
		if ((s[FX_W+1] == s[FX_W]) && (s[FX_W] == s[FX_W-1])) begin
			r = s[FX_W-1:0];
		end else if (s[FX_W+1]) begin
			r = INT64_MIN;
		end else begin
			r = INT64_MAX;
		end
		return r;
	endfunction

	// six-segment hue ramp, red in the top byte
	function automatic logic [23:0] hue_base(input logic [T_W-1:0] t);
		logic [2:0]        seg;
		logic [CHAN_W-1:0] x;
		logic [CHAN_W-1:0] full;
		logic [23:0]       c;
		seg  = t[T_W-1:CHAN_W];
		x    = t[CHAN_W-1:0];
		full = CHAN_W'(CHAN_MAX);
		case (seg)
			3'd0: c = {full, x, 8'h00};
			3'd1: c = {full - x, full, 8'h00};
			3'd2: c = {8'h00, full, x};
			3'd3: c = {8'h00, full - x, full};
			3'd4: c = {x, 8'h00, full};
			default: c = {full, 8'h00, full - x};
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/mandelbrot_escape_time_pixel_top.sv @@
// top level: sequencer for the shortcut test, escape loop and colour ramp
//
// takes one point c (signed fixed point, FRACTION_BITS fraction bits) per request
// when start is high and busy is low, and gives one result on result, marked
// by done for exactly one cycle; the receiver cannot stall, so the result must
// be captured in that cycle. busy stays high for the whole request; a new
// request may be issued in the cycle done is high. the complex arithmetic runs
// through one 64x64 multiplier built from a single 32x32 multiplier that forms
// the four partial products one after another; the two ramp divides by the
// limit use one serial divider, and the channel scaling by shade/255 is a small
// 8x8 product with a reciprocal shift, one channel per cycle. steps per
// request: accept and start, the cardioid and bulb test, the escape iterations,
// part of one more iteration when it escapes on |z|^2, then the colour ramp on
// an escaped point (two divides and three channel steps) or a direct finish
// when the limit is reached, with the multiplier the bottleneck inside the
// loop. points in the main cardioid or the period-2 bulb return black with
// zero iterations. iteration_limit is written through cfg_we / cfg_wdata and
// is clamped to ITER_CEILING; write it only while busy is low.
module mandelbrot_escape_time_pixel_top
	import mandel_pkg::*;
#(
	parameter int ITER_CEILING  = ITER_CEILING_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  point_t             point,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	output logic               done,
	output result_t            result
);

	// fixed-point constants follow the fraction width
	localparam logic [FX_W-1:0] FX_ONE  = 64'd1 << FRACTION_BITS;
	localparam logic [FX_W-1:0] FX_TWO  = 64'd2 << FRACTION_BITS;
	localparam logic [FX_W-1:0] FX_FOUR = 64'd4 << FRACTION_BITS;
	localparam logic signed [FX_W-1:0] FX_QUARTER   = $signed(64'd1 << (FRACTION_BITS - 2));
	localparam logic signed [FX_W-1:0] FX_SIXTEENTH = $signed(64'd1 << (FRACTION_BITS - 4));
	localparam logic signed [FX_W-1:0] FX_ONE_S     = $signed(FX_ONE);
	localparam logic signed [FX_W-1:0] FX_MTWO_S    = -$signed(FX_TWO);

	localparam int CMP_W = ($clog2(ITER_CEILING + 1) > LIMIT_W) ?
		$clog2(ITER_CEILING + 1) : LIMIT_W;

	// sequencer states
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_SC_GO  = 5'd1;
	localparam logic [4:0] ST_SC_Y2  = 5'd2;
	localparam logic [4:0] ST_SC_XX  = 5'd3;
	localparam logic [4:0] ST_SC_QS  = 5'd4;
	localparam logic [4:0] ST_SC_Q   = 5'd5;
	localparam logic [4:0] ST_SC_BX  = 5'd6;
	localparam logic [4:0] ST_LOOP   = 5'd7;
	localparam logic [4:0] ST_LP_X2  = 5'd8;
	localparam logic [4:0] ST_LP_Y2  = 5'd9;
	localparam logic [4:0] ST_LP_XY  = 5'd10;
	localparam logic [4:0] ST_LP_UPD = 5'd11;
	localparam logic [4:0] ST_FIN    = 5'd12;
	localparam logic [4:0] ST_DV_T   = 5'd13;
	localparam logic [4:0] ST_DV_S   = 5'd14;
	localparam logic [4:0] ST_CH_GO  = 5'd15;

	logic [4:0]         state_q;
	logic               done_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [1:0]         ch_q;

	// per-request working registers
	logic signed [FX_W-1:0] cx_q;
	logic signed [FX_W-1:0] cy_q;
	logic [LIMIT_W-1:0]     lim_q;
	logic [LIMIT_W-1:0]     iter_q;
	logic signed [FX_W-1:0] zx_q;
	logic signed [FX_W-1:0] zy_q;
	logic [FX_W-1:0]        zx2_q;
	logic [FX_W-1:0]        zy2_q;
	logic signed [FX_W-1:0] zxy_q;
	logic signed [FX_W-1:0] y2_q;
	logic signed [FX_W-1:0] x_q;
	logic signed [FX_W-1:0] q_q;
	logic                   neg_q;
	logic [T_W-1:0]         t_q;
	logic [CHAN_W-1:0]      shade_q;
	logic [23:0]            base_q;
	logic [15:0]            pix_q;
	result_t                result_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     mul_neg;

	logic [LIMIT_W-1:0]     lim_eff;
	logic [FX_W-1:0]        m_raw;
	logic [FX_W-1:0]        m_sat;
	logic signed [FX_W-1:0] fm_res;
	logic signed [FX_W-1:0] x_d;
	logic signed [FX_W-1:0] bx_d;
	logic signed [FX_W-1:0] qx_d;
	logic [FX_W-1:0]        mzx;
	logic [FX_W-1:0]        mzy;
	logic                   cy_big;
	logic                   card_win;
	logic                   bulb_win;
	logic                   card_in;
	logic                   bulb_in;
	logic                   limit_hit;
	logic                   loop_end;
	logic                   sq_esc;
	logic                   fin_inside;
	logic                   fin_limit;
	logic                   fin_colour;
	logic [FX_W+1:0]        zy_sum;
	logic [FX_W+1:0]        zx_sum;
	logic [15:0]            chan_prod;
	logic [15:0]            chan_sum;
	logic [CHAN_W-1:0]      chan_d;

	mandel_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mandel_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// limit in effect, clamped to the ceiling
	assign lim_eff = (CMP_W'(limit_q) > CMP_W'(ITER_CEILING)) ?
		LIMIT_W'(ITER_CEILING) : limit_q;

	// product back to fixed point: truncate, clamp to positive max, apply sign
	assign m_raw  = mul_rsp.prod[FRACTION_BITS +: FX_W];
	assign m_sat  = m_raw[FX_W-1] ? INT64_MAX : m_raw;
	assign fm_res = neg_q ? -$signed(m_sat) : $signed(m_sat);

	// shortcut windows and tests
	assign x_d      = cx_q - FX_QUARTER;
	assign bx_d     = cx_q + FX_ONE_S;
	assign qx_d     = q_q + x_q;
	assign cy_big   = mag64(cy_q) > FX_ONE;
	assign card_win = mag64(cx_q) <= FX_ONE;
	assign bulb_win = (cx_q <= $signed(64'd0)) && (cx_q >= FX_MTWO_S);
	assign card_in  = fm_res <= (y2_q >>> 2);
	assign bulb_in  = (fm_res + y2_q) <= FX_SIXTEENTH;

	// escape loop checks
	assign mzx       = mag64(zx_q);
	assign mzy       = mag64(zy_q);
	assign limit_hit = iter_q >= lim_q;
	assign loop_end  = limit_hit || (mzx > FX_TWO) || (mzy > FX_TWO);
	assign sq_esc    = (zx2_q + m_raw) > FX_FOUR;

	// next z, exact sums clamped to 64 bits
	assign zy_sum = {{2{zxy_q[FX_W-1]}}, zxy_q} + {{2{zxy_q[FX_W-1]}}, zxy_q}
		+ {{2{cy_q[FX_W-1]}}, cy_q};
	assign zx_sum = {{2{zx2_q[FX_W-1]}}, zx2_q} - {{2{zy2_q[FX_W-1]}}, zy2_q}
		+ {{2{cx_q[FX_W-1]}}, cx_q};

	// channel times shade, over 255: exact as (p + 1 + p/256) / 256 below 2^16
	assign chan_prod = 16'(base_q[23:16]) * 16'(shade_q);
	assign chan_sum  = chan_prod + 16'd1 + {8'h00, chan_prod[15:8]};
	assign chan_d    = chan_sum[15:8];

	// request completion
	assign fin_inside = ((state_q == ST_SC_Q) && mul_rsp.done && card_in)
		|| ((state_q == ST_SC_BX) && mul_rsp.done && bulb_in);
	assign fin_limit  = (state_q == ST_FIN) && limit_hit;
	assign fin_colour = (state_q == ST_CH_GO) && (ch_q == 2'd2);

	// operand steering for the shared multiplier and divider
	always_comb begin
		mul_req = '0;
		mul_neg = 1'b0;
		div_req = '0;
		case (state_q)
			ST_SC_GO: begin
				if (!cy_big) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag64(cy_q);
					mul_req.b     = mag64(cy_q);
				end
			end
			ST_SC_Y2: begin
				if (mul_rsp.done && card_win) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag64(x_d);
					mul_req.b     = mag64(x_d);
				end else if (mul_rsp.done && bulb_win) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag64(bx_d);
					mul_req.b     = mag64(bx_d);
				end
			end
			ST_SC_QS: begin
				mul_req.start = 1'b1;
				mul_req.a     = mag64(q_q);
				mul_req.b     = mag64(qx_d);
				mul_neg       = q_q[FX_W-1] ^ qx_d[FX_W-1];
			end
			ST_SC_Q: begin
				if (mul_rsp.done && !card_in && bulb_win) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag64(bx_d);
					mul_req.b     = mag64(bx_d);
				end
			end
			ST_LOOP: begin
				if (!loop_end) begin
					mul_req.start = 1'b1;
					mul_req.a     = mzx;
					mul_req.b     = mzx;
				end
			end
			ST_LP_X2: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = mzy;
					mul_req.b     = mzy;
				end
			end
			ST_LP_Y2: begin
				if (mul_rsp.done && !sq_esc) begin
					mul_req.start = 1'b1;
					mul_req.a     = mzx;
					mul_req.b     = mzy;
					mul_neg       = zx_q[FX_W-1] ^ zy_q[FX_W-1];
				end
			end
			ST_FIN: begin
				if (!limit_hit) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_N_W'(iter_q) * DIV_N_W'(HUE_SPAN);
					div_req.divisor  = DIV_D_W'(lim_q);
				end
			end
			ST_DV_T: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_N_W'(iter_q) * DIV_N_W'(SHADE_SPAN);
					div_req.divisor  = DIV_D_W'(lim_q);
				end
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// sequencer and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			limit_q <= LIMIT_RESET;
			ch_q    <= '0;
		end else begin
			done_q <= fin_inside || fin_limit || fin_colour;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SC_GO;
					end
				end
				ST_SC_GO: begin
					state_q <= cy_big ? ST_LOOP : ST_SC_Y2;
				end
				ST_SC_Y2: begin
					if (mul_rsp.done) begin
						if (card_win) begin
							state_q <= ST_SC_XX;
						end else if (bulb_win) begin
							state_q <= ST_SC_BX;
						end else begin
							state_q <= ST_LOOP;
						end
					end
				end
				ST_SC_XX: begin
					if (mul_rsp.done) begin
						state_q <= ST_SC_QS;
					end
				end
				ST_SC_QS: begin
					state_q <= ST_SC_Q;
				end
				ST_SC_Q: begin
					if (mul_rsp.done) begin
						if (card_in) begin
							state_q <= ST_IDLE;
						end else if (bulb_win) begin
							state_q <= ST_SC_BX;
						end else begin
							state_q <= ST_LOOP;
						end
					end
				end
				ST_SC_BX: begin
					if (mul_rsp.done) begin
						state_q <= bulb_in ? ST_IDLE : ST_LOOP;
					end
				end
				ST_LOOP: begin
					state_q <= loop_end ? ST_FIN : ST_LP_X2;
				end
				ST_LP_X2: begin
					if (mul_rsp.done) begin
						state_q <= ST_LP_Y2;
					end
				end
				ST_LP_Y2: begin
					if (mul_rsp.done) begin
						state_q <= sq_esc ? ST_FIN : ST_LP_XY;
					end
				end
				ST_LP_XY: begin
					if (mul_rsp.done) begin
						state_q <= ST_LP_UPD;
					end
				end
				ST_LP_UPD: begin
					state_q <= ST_LOOP;
				end
				ST_FIN: begin
					state_q <= limit_hit ? ST_IDLE : ST_DV_T;
				end
				ST_DV_T: begin
					if (div_rsp.done) begin
						state_q <= ST_DV_S;
					end
				end
				ST_DV_S: begin
					if (div_rsp.done) begin
						state_q <= ST_CH_GO;
						ch_q    <= '0;
					end
				end
				ST_CH_GO: begin
					// one channel scaled per cycle, red first
					if (ch_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_req.start) begin
			neg_q <= mul_neg;
		end
		if ((state_q == ST_IDLE) && start) begin
			cx_q   <= point.point_real;
			cy_q   <= point.point_imag;
			lim_q  <= lim_eff;
			iter_q <= '0;
			zx_q   <= '0;
			zy_q   <= '0;
		end
		if ((state_q == ST_SC_Y2) && mul_rsp.done) begin
			y2_q <= fm_res;
			x_q  <= x_d;
		end
		if ((state_q == ST_SC_XX) && mul_rsp.done) begin
			q_q <= fm_res + y2_q;
		end
		if ((state_q == ST_LP_X2) && mul_rsp.done) begin
			zx2_q <= m_raw;
		end
		if ((state_q == ST_LP_Y2) && mul_rsp.done) begin
			zy2_q <= m_raw;
		end
		if ((state_q == ST_LP_XY) && mul_rsp.done) begin
			zxy_q <= fm_res;
		end
		if (state_q == ST_LP_UPD) begin
			zx_q   <= $signed(sat66(zx_sum));
			zy_q   <= $signed(sat66(zy_sum));
			iter_q <= iter_q + LIMIT_W'(1);
		end
		if ((state_q == ST_DV_T) && div_rsp.done) begin
			t_q <= div_rsp.quotient[T_W-1:0];
		end
		if ((state_q == ST_DV_S) && div_rsp.done) begin
			shade_q <= CHAN_W'(SHADE_BASE) + div_rsp.quotient[CHAN_W-1:0];
			base_q  <= hue_base(t_q);
		end
		if (state_q == ST_CH_GO) begin
			base_q <= {base_q[15:0], 8'h00};
			pix_q  <= {pix_q[7:0], chan_d};
		end
		// result capture
		if (fin_inside) begin
			result_q.pixel_rgb       <= '0;
			result_q.iterations_done <= '0;
			result_q.in_set          <= 1'b1;
		end else if (fin_limit) begin
			result_q.pixel_rgb       <= '0;
			result_q.iterations_done <= iter_q;
			result_q.in_set          <= 1'b1;
		end else if (fin_colour) begin
			result_q.pixel_rgb       <= {pix_q, chan_d};
			result_q.iterations_done <= iter_q;
			result_q.in_set          <= 1'b0;
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/mandel_mul.sv @@
// shared 64x64 magnitude multiplier, one 32x32 partial product per cycle
module mandel_mul
	import mandel_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic              busy_q;
	logic [2:0]        cnt_q;
	logic              done_q;
	logic [FX_W-1:0]   a_q;
	logic [FX_W-1:0]   b_q;
	logic [FX_W-1:0]   pp_q;
	logic [1:0]        sh_q;
	logic [PROD_W-1:0] acc_q;

	logic [HALF_W-1:0] op_x;
	logic [HALF_W-1:0] op_y;
	logic [FX_W-1:0]   pp_d;
	logic [PROD_W-1:0] pp_ext;

	// partial order: lo*lo, lo*hi, hi*lo, hi*hi
	assign op_x = cnt_q[1] ? a_q[FX_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign op_y = cnt_q[0] ? b_q[FX_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign pp_d = op_x * op_y;

	always_comb begin
		case (sh_q)
			2'd0: pp_ext = {{FX_W{1'b0}}, pp_q};
			2'd1: pp_ext = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
			2'd2: pp_ext = {pp_q, {FX_W{1'b0}}};
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q <= pp_d;
				sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + pp_ext;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

@@ rtl/core/mandel_div.sv @@
// restoring divider for the palette, one quotient bit per cycle
module mandel_div
	import mandel_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_N_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_N_W-1:0] quo_q;

	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/core/mandel_checker.sv @@
// port-level checker for the mandelbrot escape-time pixel, bound to the top level
module mandel_checker
	import mandel_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// a result only appears once the request has fully finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted request always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// strobe is never high on back-to-back clock edges
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// points in the set are black
	a_set_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.in_set) |-> (result.pixel_rgb == 24'h000000))
		else $error("in-set point with non-zero colour");

	// an escaped point has run at least one iteration
	a_escape_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.in_set) |-> (result.iterations_done != '0))
		else $error("escaped point with zero iterations");

endmodule

bind mandelbrot_escape_time_pixel_top mandel_checker u_mandel_checker (.*);

@@ test/tb.sv @@
// self-checking testbench for the mandelbrot escape-time pixel block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mandel_pkg::*;

	// fixed point format and run limits
	localparam int FRAC             = FRACTION_BITS_DEF;
	localparam int IDLE_PERCENT     = 38;
	localparam int IDLE_MAX_CYCLES  = 24;
	localparam int RANDOM_PER_LIMIT = 100;
	localparam int SETTLE_CYCLES    = 64;
	// slowest item runs every iteration up to the ceiling, plus the ramp
	localparam int WATCHDOG_LIMIT   = 40000;

	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_ONE   = 64'sd1 <<< FRAC;
	localparam fx_t FX_MAX_S = INT64_MAX;
	localparam fx_t FX_MIN_S = INT64_MIN;
	localparam logic [FX_W-1:0] FX_TWO  = 64'd2 << FRAC;
	localparam logic [FX_W-1:0] FX_FOUR = 64'd4 << FRAC;

	// one request in flight towards the checker: the point and its predicted pixel
	typedef struct {
		point_t  pt;
		result_t px;
	} pixel_check_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	point_t             point;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	logic               done;
	result_t            result;

	pixel_check_t       pending_pixels[$];
	logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;
	int                 mismatch_count = 0;
	bit                 quiet_sender = 1'b0;

	mandelbrot_escape_time_pixel_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// pixel predictor
	// ---------------------------------------------------------------

	// magnitude as an unsigned value, the most negative input gives 2^63
	function automatic logic [FX_W-1:0] mag_of(fx_t v);
		return v[FX_W-1] ? -v : v;
	endfunction

	// exact product of two magnitudes, truncated to the fraction width
	function automatic logic [FX_W-1:0] scaled_mag_product(logic [FX_W-1:0] a,
			logic [FX_W-1:0] b);
		logic [PROD_W-1:0] p;
		p = {{FX_W{1'b0}}, a} * {{FX_W{1'b0}}, b};
		return p[FRAC +: FX_W];
	endfunction

	// signed product: magnitude clamped to the positive range, sign applied last
	function automatic fx_t signed_product(fx_t a, fx_t b);
		logic [FX_W-1:0] m;
		m = scaled_mag_product(mag_of(a), mag_of(b));
		if (m > INT64_MAX) begin
			m = INT64_MAX;
		end
		return (a[FX_W-1] != b[FX_W-1]) ? -fx_t'(m) : fx_t'(m);
	endfunction

	// exact three-term sum clamped to the signed range
	function automatic fx_t clamp_sum(fx_t a, fx_t b, fx_t c);
		logic signed [FX_W+1:0] s;
		s = $signed({{2{a[FX_W-1]}}, a}) + $signed({{2{b[FX_W-1]}}, b})
			+ $signed({{2{c[FX_W-1]}}, c});
		if (s > $signed({2'b00, INT64_MAX})) begin
			return FX_MAX_S;
		end
		if (s < $signed({2'b11, INT64_MIN})) begin
			return FX_MIN_S;
		end
		return s[FX_W-1:0];
	endfunction

	// cardioid and period-2 bulb shortcut, each only inside its own window
	function automatic bit in_main_body(fx_t cx, fx_t cy);
		fx_t y2, x, q, bx;
		if (mag_of(cy) > FX_ONE) begin
			return 1'b0;
		end
		y2 = signed_product(cy, cy);
		if (mag_of(cx) <= FX_ONE) begin
			x = cx - (FX_ONE >>> 2);
			q = signed_product(x, x) + y2;
			if (signed_product(q, q + x) <= (y2 >>> 2)) begin
				return 1'b1;
			end
		end
		if (cx <= 0 && cx >= -2 * FX_ONE) begin
			bx = cx + FX_ONE;
			if (signed_product(bx, bx) + y2 <= (FX_ONE >>> 4)) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// six-segment hue ramp darkened by the shade, all divides truncating
	function automatic logic [23:0] ramp_colour(int unsigned iter, int unsigned lim);
		int unsigned hue, shade, x, r, g, b;
		if (iter >= lim || lim == 0) begin
			return '0;
		end
		hue   = iter * HUE_SPAN / lim;
		shade = SHADE_BASE + iter * SHADE_SPAN / lim;
		x     = hue & 'hff;
		case (hue >> 8)
			0: begin
				r = CHAN_MAX; g = x; b = 0;
			end
			1: begin
				r = CHAN_MAX - x; g = CHAN_MAX; b = 0;
			end
			2: begin
				r = 0; g = CHAN_MAX; b = x;
			end
			3: begin
				r = 0; g = CHAN_MAX - x; b = CHAN_MAX;
			end
			4: begin
				r = x; g = 0; b = CHAN_MAX;
			end
			default: begin
				r = CHAN_MAX; g = 0; b = CHAN_MAX - x;
			end
		endcase
		r = r * shade / CHAN_MAX;
		g = g * shade / CHAN_MAX;
		b = b * shade / CHAN_MAX;
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	// full pixel: shortcut, escape loop from zero, then colour
	function automatic result_t predict_pixel(point_t p, logic [LIMIT_W-1:0] reg_value);
		int unsigned     lim;
		int unsigned     iter;
		fx_t             zx, zy, zxy;
		logic [FX_W-1:0] mx, my, zx2, zy2;
		result_t         px;
		lim  = (reg_value > ITER_CEILING_DEF) ? ITER_CEILING_DEF : reg_value;
		px   = '0;
		iter = 0;
		zx   = '0;
		zy   = '0;
		if (in_main_body(p.point_real, p.point_imag)) begin
			px.in_set = 1'b1;
			return px;
		end
		while (iter < lim) begin
			mx = mag_of(zx);
			my = mag_of(zy);
			// a component beyond two has escaped, no square taken
			if (mx > FX_TWO || my > FX_TWO) begin
				break;
			end
			zx2 = scaled_mag_product(mx, mx);
			zy2 = scaled_mag_product(my, my);
			if (({1'b0, zx2} + {1'b0, zy2}) > {1'b0, FX_FOUR}) begin
				break;
			end
			zxy  = signed_product(zx, zy);
			zy   = clamp_sum(zxy, zxy, p.point_imag);
			zx   = clamp_sum(fx_t'(zx2), -fx_t'(zy2), p.point_real);
			iter = iter + 1;
		end
		px.pixel_rgb       = ramp_colour(iter, lim);
		px.iterations_done = iter[LIMIT_W-1:0];
		px.in_set          = (iter >= lim);
		return px;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic fx_t to_fixed(real v);
		return fx_t'(longint'(v * (2.0 ** FRAC)));
	endfunction

	function automatic point_t make_point(fx_t re, fx_t im);
		point_t p;
		p.point_real = re;
		p.point_imag = im;
		return p;
	endfunction

	// mostly points around the set, some just outside, some anywhere at all
	function automatic point_t random_point();
		int unsigned pick;
		fx_t         r, i;
		pick = $urandom_range(99);
		r    = {$urandom, $urandom};
		i    = {$urandom, $urandom};
		if (pick < 70) begin
			// real part in -2.5 .. 1.5, imaginary part within one or two
			return make_point((r >>> 2) - (FX_ONE >>> 1), (pick < 40) ? (i >>> 3) : (i >>> 2));
		end else if (pick < 85) begin
			return make_point(r >>> 1, i >>> 1);
		end
		return make_point(r, i);
	endfunction

	// present one request, hold it until accepted, then record the prediction
	task automatic send_point(point_t p);
		pixel_check_t entry;
		// random gaps, which also drop start while the block is still working
		while (!quiet_sender && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, IDLE_MAX_CYCLES)) @(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy !== 1'b0);
		entry.pt = p;
		entry.px = predict_pixel(p, limit_shadow);
		pending_pixels.push_back(entry);
	endtask

	// start was left high by the last accepted request
	task automatic stop_requests();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_pixels.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	// register writes only with the block idle and nothing outstanding
	task automatic set_iteration_limit(logic [LIMIT_W-1:0] value);
		stop_requests();
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		limit_shadow  = value;
	endtask

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// field extremes, shortcut edges and window edges at the reset limit
	task automatic test_boundary_points();
		send_point(make_point(FX_MIN_S, FX_MIN_S));
		send_point(make_point(FX_MAX_S, FX_MAX_S));
		send_point(make_point(FX_MIN_S, FX_MAX_S));
		send_point(make_point(FX_MAX_S, FX_MIN_S));
		send_point(make_point(FX_MIN_S, '0));
		send_point(make_point('0, FX_MAX_S));
		// cardioid centre, cusp and neck
		send_point(make_point('0, '0));
		send_point(make_point(to_fixed(0.25), '0));
		send_point(make_point(to_fixed(-0.75), '0));
		// bulb centre and its left edge exactly
		send_point(make_point(-FX_ONE, '0));
		send_point(make_point(to_fixed(-1.25), '0));
		// on or just past the edges of the shortcut windows
		send_point(make_point(-FX_ONE, FX_ONE + 1));
		send_point(make_point(FX_ONE, FX_ONE));
		send_point(make_point(-2 * FX_ONE, FX_ONE));
		// |z|^2 sits on four without exceeding it, so the limit is reached
		send_point(make_point(-2 * FX_ONE, '0));
		// component of exactly two, escapes one step later
		send_point(make_point(2 * FX_ONE, '0));
		// slow escape just past the cusp
		send_point(make_point(to_fixed(0.26), '0));
		// periodic orbit in the set that the shortcut misses
		send_point(make_point('0, -FX_ONE));
	endtask

	// zero limit, single iteration, above the ceiling, ceiling, lowest usual
	task automatic test_limit_extremes();
		set_iteration_limit('0);
		send_point(make_point(-2 * FX_ONE, '0));
		set_iteration_limit(9'd1);
		send_point(make_point(to_fixed(0.26), '0));
		set_iteration_limit('1);
		send_point(make_point(-2 * FX_ONE, '0));
		set_iteration_limit(9'(ITER_CEILING_DEF));
		send_point(make_point(to_fixed(0.26), '0));
		set_iteration_limit(9'd48);
		send_point(make_point(to_fixed(-0.1), to_fixed(0.9)));
	endtask

	// random points across a series of limits, one stretch without gaps
	task automatic test_random_points();
		logic [LIMIT_W-1:0] plan [10] = '{9'd72, 9'd48, 9'd288, 9'd511, 9'd160,
			9'd0, 9'd1, 9'd255, 9'd100, 9'd300};
		foreach (plan[k]) begin
			set_iteration_limit(plan[k]);
			quiet_sender = (k == 4);
			repeat (RANDOM_PER_LIMIT) send_point(random_point());
		end
		quiet_sender = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// result checker: every done pixel against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_pixels
		pixel_check_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %h with no request outstanding", result));
			end else begin
				want = pending_pixels.pop_front();
				if (result.pixel_rgb !== want.px.pixel_rgb) begin
					report_mismatch($sformatf("point %h colour %h, predicted %h",
						want.pt, result.pixel_rgb, want.px.pixel_rgb));
				end
				if (result.iterations_done !== want.px.iterations_done) begin
					report_mismatch($sformatf("point %h iterations %0d, predicted %0d",
						want.pt, result.iterations_done, want.px.iterations_done));
				end
				if (result.in_set !== want.px.in_set) begin
					report_mismatch($sformatf("point %h in_set %b, predicted %b",
						want.pt, result.in_set, want.px.in_set));
				end
			end
		end
	end

	// watchdog: ends the run after too long with no request or pixel moving
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// sequence of tests
	// ---------------------------------------------------------------
	initial begin
		// every input known from the first instant, reset held low before release
		start     <= 1'b0;
		point     <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_boundary_points();
		test_limit_extremes();
		test_random_points();

		// let the last pixels arrive, then a short quiet spell for strays
		stop_requests();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
